@@ rtl/core/llq_pkg.sv @@
// shared constants, codes and types for the linked-list queue
`timescale 1ns / 1ps
package llq_pkg;

  localparam int DEF_POOL_DEPTH = 32;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int ERR_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_HEAD,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic link_step;
    logic head_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_list;
    logic cur_pop;
    logic occ_zero;
    logic out_busy;
  } dp_status_t;

endpackage

@@ rtl/core/llq_ifs.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface llq_req_if;
  import llq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink   (input valid, command, push_value, output ready);
endinterface

interface llq_res_if;
  import llq_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] popped_value;
  logic [VALUE_W-1:0] head_value;
  logic [VALUE_W-1:0] tail_value;
  logic [COUNT_W-1:0] entry_count;
  logic               queue_empty;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, popped_value, head_value, tail_value, entry_count,
                  queue_empty, error_code, input ready);
  modport sink   (input valid, popped_value, head_value, tail_value, entry_count,
                  queue_empty, error_code, output ready);
endinterface

@@ rtl/core/llq_ctrl.sv @@
// sequencing state machine for the linked-list queue
`timescale 1ns / 1ps
module llq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  llq_pkg::dp_status_t    status,
  output llq_pkg::ctrl_cmd_t     ctrl
);
  import llq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctrl.start = 1'b1;
          state_next = status.go_list ? ST_LINK : ST_DONE;
        end
      end
      ST_LINK: begin
        ctrl.link_step = 1'b1;
        // a pop that leaves entries behind needs the new head's value
        state_next = (status.cur_pop && !status.occ_zero) ? ST_HEAD : ST_DONE;
      end
      ST_HEAD: begin
        ctrl.head_step = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          ctrl.finish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/llq_dp.sv @@
// node pool memories, list pointers and result register
`timescale 1ns / 1ps
module llq_dp #(
  parameter int POOL_DEPTH = llq_pkg::DEF_POOL_DEPTH,
  parameter int DATA_WIDTH = llq_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  llq_pkg::ctrl_cmd_t          ctrl,
  output llq_pkg::dp_status_t         status,
  input  logic [llq_pkg::CMD_W-1:0]   command,
  input  logic [llq_pkg::VALUE_W-1:0] push_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [llq_pkg::VALUE_W-1:0] popped_value,
  output logic [llq_pkg::VALUE_W-1:0] head_value,
  output logic [llq_pkg::VALUE_W-1:0] tail_value,
  output logic [llq_pkg::COUNT_W-1:0] entry_count,
  output logic                        queue_empty,
  output logic [llq_pkg::ERR_W-1:0]   error_code
);
  import llq_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int OCC_W = $clog2(POOL_DEPTH + 1);

  logic [IDX_W-1:0]      link_mem [POOL_DEPTH];
  logic [DATA_WIDTH-1:0] val_mem  [POOL_DEPTH];
  logic [IDX_W-1:0]      link_rd;
  logic [DATA_WIDTH-1:0] val_rd;

  logic [IDX_W-1:0]      head_idx;
  logic [IDX_W-1:0]      tail_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      node_idx;
  logic                  node_fresh;
  logic [OCC_W-1:0]      fresh_cnt;
  logic [OCC_W-1:0]      occ;
  logic [DATA_WIDTH-1:0] head_val;
  logic [DATA_WIDTH-1:0] tail_val;
  logic [DATA_WIDTH-1:0] popped;
  logic [ERR_W-1:0]      err;
  logic                  op_push;
  logic                  op_pop;

  logic [DATA_WIDTH-1:0] push_data;
  logic                  occ_zero;
  logic                  occ_full;
  logic                  go_push;
  logic                  go_pop;
  logic                  lk_we;
  logic [IDX_W-1:0]      lk_waddr;
  logic [IDX_W-1:0]      lk_raddr;
  logic                  is_fresh;
  logic [IDX_W-1:0]      node_inc;

  assign push_data = DATA_WIDTH'(push_value);
  assign occ_zero  = (occ == '0);
  assign occ_full  = (occ == OCC_W'(POOL_DEPTH));
  assign go_push   = (command == CMD_PUSH) && !occ_full;
  assign go_pop    = (command == CMD_POP) && !occ_zero;

  // entries at or above the fill mark were never written and are treated as linking to i plus one
  assign is_fresh  = (OCC_W'(free_idx) == fresh_cnt);
  assign node_inc  = (node_idx == IDX_W'(POOL_DEPTH - 1)) ? '0 : node_idx + 1'b1;

  // one write and one read of the link store per cycle
  assign lk_we    = ctrl.start && ((go_push && !occ_zero) || go_pop);
  assign lk_waddr = go_push ? tail_idx : head_idx;
  assign lk_raddr = go_push ? free_idx : head_idx;

  assign status.go_list  = go_push || go_pop;
  assign status.cur_pop  = op_pop;
  assign status.occ_zero = occ_zero;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= free_idx;
    end
    if (ctrl.start) begin
      link_rd <= link_mem[lk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && go_push) begin
      val_mem[free_idx] <= push_data;
    end
    if (ctrl.link_step) begin
      val_rd <= val_mem[link_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx  <= '0;
      tail_idx  <= '0;
      free_idx  <= '0;
      fresh_cnt <= '0;
      occ       <= '0;
      op_push   <= 1'b0;
      op_pop    <= 1'b0;
    end else begin
      if (ctrl.start) begin
        op_push <= go_push;
        op_pop  <= go_pop;
        if (go_push) begin
          tail_idx <= free_idx;
          occ      <= occ + 1'b1;
          if (occ_zero) begin
            head_idx <= free_idx;
          end
          if (is_fresh) begin
            fresh_cnt <= fresh_cnt + 1'b1;
          end
        end else if (go_pop) begin
          free_idx <= head_idx;
          occ      <= occ - 1'b1;
        end
      end
      if (ctrl.link_step) begin
        if (op_push) begin
          free_idx <= node_fresh ? node_inc : link_rd;
        end
        if (op_pop) begin
          head_idx <= link_rd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      node_idx   <= free_idx;
      node_fresh <= is_fresh;
      popped     <= go_pop ? head_val : '0;
      if (command == CMD_PUSH && occ_full) begin
        err <= ERR_FULL;
      end else if (command == CMD_POP && occ_zero) begin
        err <= ERR_EMPTY;
      end else begin
        err <= ERR_OK;
      end
      if (go_push) begin
        tail_val <= push_data;
        if (occ_zero) begin
          head_val <= push_data;
        end
      end
    end
    if (ctrl.head_step) begin
      head_val <= val_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      popped_value <= VALUE_W'(popped);
      head_value   <= occ_zero ? '0 : VALUE_W'(head_val);
      tail_value   <= occ_zero ? '0 : VALUE_W'(tail_val);
      entry_count  <= COUNT_W'(occ);
      queue_empty  <= occ_zero;
      error_code   <= err;
    end
  end

endmodule

@@ rtl/core/linked_list_fifo_with_free_list.sv @@
// top level of the linked-list queue with free list
//
// a fifo kept as a linked list in a pool of POOL_DEPTH nodes; free nodes
// are chained through the same link store
// request channel carries command (push, pop, status) and push_value;
// every request item yields exactly one result item on the result channel
// with the popped value, head and tail values, entry count, empty flag and
// an error code (push when full and pop when empty change nothing)
// a status read or a refused command goes straight to the result write;
// a push and a pop first pass through the registered reads of the link
// and value stores: a pop reads the head's link, then the value of the
// new head, and only a pop that leaves entries behind needs that value
// one item is in work at a time; request ready is high only while idle,
// so the next request is taken only after the last result is written
// a finished result sits in an output register, so the next request can
// be taken while the receiver stalls; a result that cannot be written
// because that register is still full holds the block until it drains
// reset holds request ready low, empties the queue and makes the whole pool
// the free list at once; untouched link entries are covered by a fill mark
`timescale 1ns / 1ps
module linked_list_fifo_with_free_list #(
  parameter int POOL_DEPTH = llq_pkg::DEF_POOL_DEPTH,
  parameter int DATA_WIDTH = llq_pkg::DEF_DATA_WIDTH
) (
  input logic       clk,
  input logic       rst,
  llq_req_if.sink   request,
  llq_res_if.source result
);
  import llq_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // sequencer: idle, link read, head value read, result write
  llq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // pool memories, pointers, fill mark and output register
  llq_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .command      (request.command),
    .push_value   (request.push_value),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .popped_value (result.popped_value),
    .head_value   (result.head_value),
    .tail_value   (result.tail_value),
    .entry_count  (result.entry_count),
    .queue_empty  (result.queue_empty),
    .error_code   (result.error_code)
  );

endmodule

@@ rtl/core/llq_chk.sv @@
// port-level checks for the linked-list queue, bound to the top level
`timescale 1ns / 1ps
module llq_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [llq_pkg::VALUE_W-1:0] popped_value,
  input logic [llq_pkg::VALUE_W-1:0] head_value,
  input logic [llq_pkg::VALUE_W-1:0] tail_value,
  input logic [llq_pkg::COUNT_W-1:0] entry_count,
  input logic                        queue_empty,
  input logic [llq_pkg::ERR_W-1:0]   error_code
);
  import llq_pkg::*;

  // empty flag agrees with the count (count is the low bits of occupancy,
  // so only a nonzero count is checked against the flag)
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && entry_count != '0 |-> !queue_empty)
    else $error("queue_empty set with nonzero entry_count");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    res_valid && queue_empty |-> head_value == '0 && tail_value == '0)
    else $error("empty queue reports head or tail value");

  a_refused_pop: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code == ERR_EMPTY |-> queue_empty && popped_value == '0)
    else $error("refused pop reports data or a nonempty queue");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(popped_value)
      && $stable(head_value) && $stable(tail_value) && $stable(error_code))
    else $error("result item changed while stalled");

endmodule

bind linked_list_fifo_with_free_list llq_chk u_llq_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .popped_value (result.popped_value),
  .head_value   (result.head_value),
  .tail_value   (result.tail_value),
  .entry_count  (result.entry_count),
  .queue_empty  (result.queue_empty),
  .error_code   (result.error_code)
);

@@ bench/linked_list_fifo_with_free_list_tb.sv @@
// self-checking bench for the linked-list queue: directed, random and stall tests
`timescale 1ns / 1ps
module linked_list_fifo_with_free_list_tb;
  import llq_pkg::*;

  localparam int POOL_DEPTH = DEF_POOL_DEPTH;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 80;

  // the fourth command code has no name in the package; it acts as a status read
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // how the random part leans between push and pop
  typedef enum logic [1:0] {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_EVEN
  } lean_t;

  // one result item as the queue should report it
  typedef struct {
    logic [VALUE_W-1:0] popped_value;
    logic [VALUE_W-1:0] head_value;
    logic [VALUE_W-1:0] tail_value;
    logic [COUNT_W-1:0] entry_count;
    logic               queue_empty;
    logic [ERR_W-1:0]   error_code;
  } queue_status_t;

  logic clk;
  logic rst;

  llq_req_if req_ch ();
  llq_res_if res_ch ();

  linked_list_fifo_with_free_list dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  // shadow copy of the node pool: links, values and the three list pointers
  logic [IDX_W-1:0]   node_link [POOL_DEPTH];
  logic [VALUE_W-1:0] node_value [POOL_DEPTH];
  logic [IDX_W-1:0]   head_node;
  logic [IDX_W-1:0]   tail_node;
  logic [IDX_W-1:0]   free_node;
  int                 queued_count;

  // status items owed by the block, oldest first
  queue_status_t status_due [$];

  int fail_count;
  bit gaps_on;        // random idling on both channels
  bit hold_request;   // asks the receiver for one long hold

  // clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard limit on the run, far above the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // apply one command to the shadow pool and return the status it yields
  function automatic queue_status_t queue_step(logic [CMD_W-1:0] cmd,
                                               logic [VALUE_W-1:0] value);
    queue_status_t    st;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] next_node;
    st.popped_value = '0;
    st.error_code   = ERR_OK;
    case (cmd)
      CMD_PUSH: begin
        if (queued_count >= POOL_DEPTH) begin
          // full: nothing moves
          st.error_code = ERR_FULL;
        end else begin
          // take the free-list head and hang it after the tail
          node = free_node;
          free_node = node_link[node];
          node_value[node] = value;
          if (queued_count == 0) begin
            head_node = node;
          end else begin
            node_link[tail_node] = node;
          end
          tail_node = node;
          queued_count++;
        end
      end
      CMD_POP: begin
        if (queued_count == 0) begin
          st.error_code = ERR_EMPTY;
        end else begin
          // unlink the head and push it onto the front of the free list
          node = head_node;
          next_node = node_link[node];
          st.popped_value = node_value[node];
          node_link[node] = free_node;
          free_node = node;
          head_node = next_node;
          queued_count--;
        end
      end
      default: begin
        // status read, and the spare code behaves the same
      end
    endcase
    if (queued_count != 0) begin
      st.head_value = node_value[head_node];
      st.tail_value = node_value[tail_node];
    end else begin
      st.head_value = '0;
      st.tail_value = '0;
    end
    st.entry_count = COUNT_W'(queued_count);
    st.queue_empty = (queued_count == 0);
    return st;
  endfunction

  // random data word with extra weight on all zeros and all ones
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one item; valid stays high after acceptance so back-to-back
  // items never drop it; a gap lowers it at the acceptance edge instead
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    status_due.push_back(queue_step(cmd, value));
  endtask

  // result side: check each accepted item, then pick ready for the next cycle
  initial begin
    int            hold_left;
    int            stall_left;
    queue_status_t want;
    hold_left  = 0;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (status_due.size() == 0) begin
          $error("result item with no request outstanding");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (res_ch.popped_value !== want.popped_value) begin
            $error("popped_value: expected %h, got %h", want.popped_value,
                   res_ch.popped_value);
            fail_count++;
          end
          if (res_ch.head_value !== want.head_value) begin
            $error("head_value: expected %h, got %h", want.head_value, res_ch.head_value);
            fail_count++;
          end
          if (res_ch.tail_value !== want.tail_value) begin
            $error("tail_value: expected %h, got %h", want.tail_value, res_ch.tail_value);
            fail_count++;
          end
          if (res_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   res_ch.entry_count);
            fail_count++;
          end
          if (res_ch.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %b, got %b", want.queue_empty,
                   res_ch.queue_empty);
            fail_count++;
          end
          if (res_ch.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   res_ch.error_code);
            fail_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        // long hold: the block must park its result and stop taking requests
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // empty queue corner cases, both value extremes, every command code
  task automatic test_directed();
    send_item(CMD_STATUS, '0);
    send_item(CMD_SPARE, '1);
    send_item(CMD_POP, '0);          // pop on empty is refused
    send_item(CMD_PUSH, '0);         // push into empty sets head and tail
    send_item(CMD_STATUS, '0);
    send_item(CMD_PUSH, '1);
    send_item(CMD_PUSH, 32'h8000_0001);
    send_item(CMD_SPARE, '0);
    send_item(CMD_POP, '1);
    send_item(CMD_POP, '0);
    send_item(CMD_POP, '0);          // leaves the queue empty
    send_item(CMD_POP, '0);
    send_item(CMD_PUSH, 32'h5555_5555);
    send_item(CMD_PUSH, 32'hAAAA_AAAA);
    send_item(CMD_POP, '0);
    send_item(CMD_POP, '0);
  endtask

  // fill the pool, push against full, recycle a node while full, drain past empty
  task automatic test_fill_and_drain();
    for (int i = 0; i < POOL_DEPTH; i++) send_item(CMD_PUSH, rand_word());
    send_item(CMD_PUSH, '1);         // full: refused
    send_item(CMD_SPARE, '0);
    send_item(CMD_PUSH, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_PUSH, rand_word());
    send_item(CMD_PUSH, rand_word());
    for (int i = 0; i <= POOL_DEPTH; i++) send_item(CMD_POP, '0);
  endtask

  // random commands; the lean wanders so the count sweeps from empty to full
  task automatic random_run(int n_items);
    lean_t            lean;
    int               pick;
    logic [CMD_W-1:0] cmd;
    lean = LEAN_EVEN;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 39) == 0) lean = lean_t'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      case (lean)
        LEAN_FILL:  cmd = (pick < 70) ? CMD_PUSH : (pick < 90) ? CMD_POP : CMD_STATUS;
        LEAN_DRAIN: cmd = (pick < 70) ? CMD_POP : (pick < 90) ? CMD_PUSH : CMD_STATUS;
        default:    cmd = (pick < 45) ? CMD_PUSH : (pick < 90) ? CMD_POP : CMD_STATUS;
      endcase
      if (pick == 99) cmd = CMD_SPARE;
      send_item(cmd, rand_word());
    end
  endtask

  task automatic test_random();
    for (int blk = 0; blk < RANDOM_ITEMS / 50; blk++) begin
      // some stretches run with no idling at all
      gaps_on = ($urandom_range(0, 3) != 0);
      random_run(50);
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off for a long time while requests keep coming
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    random_run(40);
    gaps_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    gaps_on = 1'b0;
    random_run(QUIET_ITEMS);
  endtask

  initial begin
    fail_count   = 0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    // shadow pool starts as one free list through every node
    for (int i = 0; i < POOL_DEPTH; i++) begin
      node_link[i]  = IDX_W'(i + 1);
      node_value[i] = '0;
    end
    head_node    = '0;
    tail_node    = '0;
    free_node    = '0;
    queued_count = 0;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_STATUS;
    req_ch.push_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random();
    test_backpressure();
    test_full_rate();

    // all items offered: wait for every result, then a short tail
    req_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ linked_list_fifo_with_free_list.f @@
rtl/core/llq_pkg.sv
rtl/core/llq_ifs.sv
rtl/core/llq_ctrl.sv
rtl/core/llq_dp.sv
rtl/core/linked_list_fifo_with_free_list.sv
rtl/core/llq_chk.sv
bench/linked_list_fifo_with_free_list_tb.sv
